// ===== src/spq_pkg.sv =====
// Shared constants, codes and types of the stable priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned OCC_BITS = 5;
  localparam int unsigned ACT_BITS = 2;
  localparam int unsigned FLT_BITS = 2;

  localparam logic [ACT_BITS-1:0] ACT_INSERT_AFTER  = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_INSERT_BEFORE = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE        = 2'd2;

  localparam logic [FLT_BITS-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FLT_BITS-1:0] FAULT_FULL  = 2'd1;
  localparam logic [FLT_BITS-1:0] FAULT_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic front;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// One storage cell of the sorted shifting store.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  logic               occ_i,
  input  logic               left_go_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               go_o,
  output spq_pkg::entry_t    q_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // The cell stays put when it holds a key that belongs ahead of the new one.
  always_comb begin
    if (ctrl_i.front) begin
      go_o = occ_i && (entry_q.key < new_i.key);
    end else begin
      go_o = occ_i && (entry_q.key <= new_i.key);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && !go_o) begin
      entry_d = left_go_i ? new_i : left_i;
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

// ===== src/stable_priority_queue.sv =====
// Top level of the stable priority queue: cell chain, fill count and result register.
//
// The block takes one action in every cycle: busy stays low, so an action is
// transferred at each rising edge with start high. The result of an action
// appears on the result ports in the next cycle, for exactly one cycle, with
// result_valid_o high; the receiver cannot stall it and must take it then.
// Every cell of the chain makes a single key compare against the incoming
// key. Entries stay sorted by ascending key with the head in the first cell.
// A normal insert lands after all equal keys, a front insert before them,
// and a remove hands out the head while every cell but the last copies its
// right neighbor and the last keeps its own entry. An insert into a full
// queue or a remove from an empty one leaves the store untouched and reports
// a fault. Unused action codes change nothing and report the occupancy.
module stable_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [spq_pkg::ACT_BITS-1:0]  action_i,
  input  logic [spq_pkg::KEY_BITS-1:0]  key_i,
  input  logic [spq_pkg::TAG_BITS-1:0]  item_tag_i,
  output logic                          result_valid_o,
  output logic                          removed_valid_o,
  output logic [spq_pkg::KEY_BITS-1:0]  removed_key_o,
  output logic [spq_pkg::TAG_BITS-1:0]  removed_tag_o,
  output logic [spq_pkg::OCC_BITS-1:0]  occupancy_o,
  output logic [spq_pkg::FLT_BITS-1:0]  fault_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_BITS-1:0] count_q;
  logic [spq_pkg::CNT_BITS-1:0] count_d;

  logic                          is_insert;
  logic                          is_remove;
  logic                          full;
  logic                          empty;
  logic [spq_pkg::FLT_BITS-1:0]  fault_d;
  spq_pkg::cell_ctrl_t           ctrl;
  spq_pkg::entry_t               new_entry;

  spq_pkg::entry_t cell_q   [N];
  logic [N-1:0]    cell_go;
  logic [N-1:0]    cell_occ;

  // The block never holds off an action.
  assign busy = 1'b0;

  assign full  = (count_q == spq_pkg::CNT_BITS'(N));
  assign empty = (count_q == '0);

  assign is_insert = start && ((action_i == spq_pkg::ACT_INSERT_AFTER) ||
                               (action_i == spq_pkg::ACT_INSERT_BEFORE));
  assign is_remove = start && (action_i == spq_pkg::ACT_REMOVE);

  // Faulted actions reach the cells as no-ops, so the store keeps its contents.
  assign ctrl.insert = is_insert && !full;
  assign ctrl.front  = (action_i == spq_pkg::ACT_INSERT_BEFORE);
  assign ctrl.remove = is_remove && !empty;

  assign new_entry.key = key_i;
  assign new_entry.tag = item_tag_i;

  always_comb begin
    count_d = count_q;
    fault_d = spq_pkg::FAULT_NONE;
    if (is_insert && full) begin
      fault_d = spq_pkg::FAULT_FULL;
    end else if (is_remove && empty) begin
      fault_d = spq_pkg::FAULT_EMPTY;
    end
    if (ctrl.insert) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.remove) begin
      count_d = count_q - 1'b1;
    end
  end

  // Each cell sees its left neighbor's decision and data and its right
  // neighbor's data. The first cell treats the incoming entry as its left
  // side, and the last cell holds its own entry when the chain shifts left.
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_go;

    assign cell_occ[i] = (spq_pkg::CNT_BITS'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_go    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_inner
      assign left_go    = cell_go[i-1];
      assign left_entry = cell_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = cell_q[i];
    end else begin : g_mid
      assign right_entry = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .occ_i     (cell_occ[i]),
      .left_go_i (left_go),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .go_o      (cell_go[i]),
      .q_o       (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      result_valid_o  <= 1'b0;
      removed_valid_o <= 1'b0;
      fault_o         <= spq_pkg::FAULT_NONE;
    end else begin
      count_q         <= count_d;
      result_valid_o  <= start;
      removed_valid_o <= ctrl.remove;
      fault_o         <= fault_d;
    end
  end

  // Payload of the result register; the head is captured before it shifts out.
  always_ff @(posedge clk_i) begin
    if (ctrl.remove) begin
      removed_key_o <= cell_q[0].key;
      removed_tag_o <= cell_q[0].tag;
    end else begin
      removed_key_o <= '0;
      removed_tag_o <= '0;
    end
    occupancy_o <= spq_pkg::OCC_BITS'(count_d);
  end

endmodule
